// File: sv/dss_pkg.sv
// Shared constants and types for the delimiter segment splitter.
`default_nettype none

package dss_pkg;

  localparam int MAX_DELIM_DEF = 8;
  localparam int MAX_LEN_DEF   = 65536;

  localparam int BYTE_W        = 8;
  localparam int DELIM_BYTES_W = 64;
  localparam int DELIM_LEN_W   = 4;
  localparam int FIELD_W       = 16;

  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  localparam logic [DELIM_BYTES_W-1:0] DELIM_BYTES_RST = '0;
  localparam logic [DELIM_LEN_W-1:0]   DELIM_LEN_RST   = DELIM_LEN_W'(1);

  typedef enum logic [0:0] {
    REG_DELIM_BYTES = 1'b0,
    REG_DELIM_LEN   = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

// File: sv/dss_match.sv
// Parallel compare of the recent byte window against the delimiter pattern.
`default_nettype none

module dss_match #(
  parameter int MAX_DELIM = dss_pkg::MAX_DELIM_DEF
) (
  input  wire logic [MAX_DELIM*dss_pkg::BYTE_W-1:0] window,
  input  wire logic [dss_pkg::DELIM_BYTES_W-1:0]    pattern,
  input  wire logic [dss_pkg::DELIM_LEN_W-1:0]      len,
  output logic                                      match
);

  logic [MAX_DELIM:1] hit;

  // Pattern byte k pairs with the window byte len-1-k places back from the newest.
  always_comb begin
    hit   = '0;
    match = 1'b0;
    for (int l = 1; l <= MAX_DELIM; l++) begin
      hit[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (window[dss_pkg::BYTE_W*(l-1-k) +: dss_pkg::BYTE_W] !=
            pattern[dss_pkg::BYTE_W*k +: dss_pkg::BYTE_W]) begin
          hit[l] = 1'b0;
        end
      end
    end
    for (int l = 1; l <= MAX_DELIM; l++) begin
      if (len == dss_pkg::DELIM_LEN_W'(l)) begin
        match = hit[l];
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/delimiter_segment_splitter.sv
// Top level of the delimiter segment splitter: item registers, string state and result register.
// A result is registered: its byte passes the input register, then the result register.
// Throughput: one byte per cycle while no result is held; window compare and segment arithmetic sit in one stage.
// A byte waits in the input register while an earlier result is still held by the receiver.
// Reset clears all string state and empties both item registers; the delimiter resets to length 1, byte 0.
// String state clears again after every final byte.
`default_nettype none

module delimiter_segment_splitter #(
  parameter int MAX_DELIM = dss_pkg::MAX_DELIM_DEF,
  parameter int MAX_LEN   = dss_pkg::MAX_LEN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire dss_pkg::cfg_idx_t                   cfg_index,
  input  wire logic [dss_pkg::DELIM_BYTES_W-1:0]   cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [dss_pkg::BYTE_W-1:0]          text_byte,
  input  wire logic                                end_of_string,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [dss_pkg::FIELD_W-1:0]              segment_start,
  output logic [dss_pkg::FIELD_W-1:0]              segment_length,
  output logic                                     final_segment,
  output logic [dss_pkg::FIELD_W-1:0]              segment_total,
  output logic [dss_pkg::FIELD_W-1:0]              nonempty_total,
  output logic                                     length_overflow
);

  localparam int WIN_W = MAX_DELIM * dss_pkg::BYTE_W;
  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int LEN_W = POS_W + 1;
  localparam int SAT_W = (LEN_W > dss_pkg::FIELD_W + 1) ? LEN_W : dss_pkg::FIELD_W + 1;
  localparam int BIS_W = $clog2(MAX_DELIM + 1);
  localparam int LW    = dss_pkg::DELIM_LEN_W;

  // configuration
  logic [dss_pkg::DELIM_BYTES_W-1:0] delim_bytes;
  logic [LW-1:0]                     delim_len;

  // input register
  logic                         in_valid_q;
  logic [dss_pkg::BYTE_W-1:0]   in_byte_q;
  logic                         in_last_q;

  // string state
  logic [WIN_W-1:0]             recent;
  logic [POS_W-1:0]             pos;
  logic [POS_W-1:0]             cur_start;
  logic [BIS_W-1:0]             bis;
  logic [dss_pkg::FIELD_W-1:0]  segs;
  logic [dss_pkg::FIELD_W-1:0]  nonempty;
  logic                         overflow;

  // datapath
  logic                         fire;
  logic [LW-1:0]                len_eff;
  logic [WIN_W-1:0]             recent_next;
  logic                         pos_sat;
  logic [POS_W-1:0]             pos_next;
  logic                         overflow_next;
  logic [BIS_W-1:0]             bis_next;
  logic                         window_match;
  logic                         match_hit;
  logic                         emit;
  logic [LEN_W-1:0]             end_x;
  logic [LEN_W-1:0]             start_x;
  logic [LEN_W-1:0]             dlen_x;
  logic [LEN_W-1:0]             seg_len;
  logic [SAT_W-1:0]             start_w;
  logic [SAT_W-1:0]             len_w;
  logic [dss_pkg::FIELD_W-1:0]  start_sat;
  logic [dss_pkg::FIELD_W-1:0]  len_sat;
  logic [dss_pkg::FIELD_W-1:0]  segs_next;
  logic [dss_pkg::FIELD_W-1:0]  nonempty_next;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid_q && (!out_valid || out_ready);
  assign in_ready  = !in_valid_q || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes <= dss_pkg::DELIM_BYTES_RST;
      delim_len   <= dss_pkg::DELIM_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dss_pkg::REG_DELIM_BYTES: delim_bytes <= cfg_data;
        dss_pkg::REG_DELIM_LEN:   delim_len   <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_q <= text_byte;
      in_last_q <= end_of_string;
    end
  end

  assign len_eff = (delim_len > LW'(MAX_DELIM)) ? LW'(MAX_DELIM) : delim_len;

  assign recent_next   = (recent << dss_pkg::BYTE_W) | WIN_W'(in_byte_q);
  assign pos_sat       = (pos >= POS_W'(MAX_LEN));
  assign pos_next      = pos_sat ? pos : pos + POS_W'(1);
  assign overflow_next = overflow || pos_sat;
  assign bis_next      = (bis == BIS_W'(MAX_DELIM)) ? bis : bis + BIS_W'(1);

  dss_match #(
    .MAX_DELIM (MAX_DELIM)
  ) u_match (
    .window  (recent_next),
    .pattern (delim_bytes),
    .len     (len_eff),
    .match   (window_match)
  );

  // A delimiter counts only when all of its bytes lie inside the current segment.
  assign match_hit = (len_eff != '0) && (LW'(bis_next) >= len_eff) && window_match;
  assign emit      = match_hit || in_last_q;

  assign end_x   = LEN_W'(pos_next);
  assign start_x = LEN_W'(cur_start);
  assign dlen_x  = LEN_W'(len_eff);

  // Past the length limit the end stalls, so a closing delimiter could leave a negative length; it is clamped to zero.
  always_comb begin
    if (match_hit) begin
      seg_len = (end_x >= start_x + dlen_x) ? end_x - dlen_x - start_x : '0;
    end else begin
      seg_len = (end_x >= start_x) ? end_x - start_x : '0;
    end
  end

  assign start_w   = SAT_W'(cur_start);
  assign len_w     = SAT_W'(seg_len);
  assign start_sat = (start_w > SAT_W'(dss_pkg::FIELD_MAX)) ? dss_pkg::FIELD_MAX :
                     start_w[dss_pkg::FIELD_W-1:0];
  assign len_sat   = (len_w > SAT_W'(dss_pkg::FIELD_MAX)) ? dss_pkg::FIELD_MAX :
                     len_w[dss_pkg::FIELD_W-1:0];

  assign segs_next     = (segs == dss_pkg::FIELD_MAX) ? segs : segs + dss_pkg::FIELD_W'(1);
  assign nonempty_next = ((seg_len != '0) && (nonempty != dss_pkg::FIELD_MAX)) ?
                         nonempty + dss_pkg::FIELD_W'(1) : nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      recent    <= '0;
      pos       <= '0;
      cur_start <= '0;
      bis       <= '0;
      segs      <= '0;
      nonempty  <= '0;
      overflow  <= 1'b0;
    end else if (fire) begin
      if (in_last_q) begin
        recent    <= '0;
        pos       <= '0;
        cur_start <= '0;
        bis       <= '0;
        segs      <= '0;
        nonempty  <= '0;
        overflow  <= 1'b0;
      end else begin
        recent   <= recent_next;
        pos      <= pos_next;
        overflow <= overflow_next;
        if (match_hit) begin
          cur_start <= pos_next;
          bis       <= '0;
          segs      <= segs_next;
          nonempty  <= nonempty_next;
        end else begin
          bis <= bis_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      segment_start   <= start_sat;
      segment_length  <= len_sat;
      final_segment   <= in_last_q;
      segment_total   <= segs_next;
      nonempty_total  <= nonempty_next;
      length_overflow <= overflow_next;
    end
  end

  a_bis_range: assert property (@(posedge clk) disable iff (rst)
    bis <= BIS_W'(MAX_DELIM))
    else $error("segment byte count beyond delimiter window");

  a_start_le_pos: assert property (@(posedge clk) disable iff (rst)
    cur_start <= pos)
    else $error("segment start ahead of byte position");

  a_nonempty_le_total: assert property (@(posedge clk) disable iff (rst)
    nonempty <= segs)
    else $error("non-empty count exceeds segment count");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && in_last_q |=> (pos == '0) && (segs == '0) && !overflow)
    else $error("string state not cleared after final byte");

endmodule

`default_nettype wire

// File: tb/delimiter_segment_splitter_checker.sv
// Channel monitor for the delimiter segment splitter: segment prediction and comparison.
module delimiter_segment_splitter_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  dss_pkg::cfg_idx_t                   cfg_index,
  input  logic [dss_pkg::DELIM_BYTES_W-1:0]   cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [dss_pkg::BYTE_W-1:0]          text_byte,
  input  logic                                end_of_string,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [dss_pkg::FIELD_W-1:0]         segment_start,
  input  logic [dss_pkg::FIELD_W-1:0]         segment_length,
  input  logic                                final_segment,
  input  logic [dss_pkg::FIELD_W-1:0]         segment_total,
  input  logic [dss_pkg::FIELD_W-1:0]         nonempty_total,
  input  logic                                length_overflow,
  output int                                  mismatches,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [dss_pkg::FIELD_W-1:0] start;
    logic [dss_pkg::FIELD_W-1:0] length;
    logic                        fin;
    logic [dss_pkg::FIELD_W-1:0] total;
    logic [dss_pkg::FIELD_W-1:0] nonempty;
    logic                        ovf;
  } segment_t;

  logic [dss_pkg::DELIM_BYTES_W-1:0] delim_pattern = dss_pkg::DELIM_BYTES_RST;
  logic [dss_pkg::DELIM_LEN_W-1:0]   delim_len = dss_pkg::DELIM_LEN_RST;

  // per-string state; start and position may reach MAX_LEN itself, so keep them as int
  logic [63:0] history;
  int          position;
  int          seg_base;
  int          in_segment;
  int          seg_count;
  int          nonempty_count;
  bit          overflowed;

  segment_t    expected_segments[$];
  int          errors = 0;

  function automatic logic [dss_pkg::FIELD_W-1:0] clamp16(input int v);
    return (v > 65535) ? dss_pkg::FIELD_MAX : v[dss_pkg::FIELD_W-1:0];
  endfunction

  function automatic void clear_string();
    history = '0;
    position = 0;
    seg_base = 0;
    in_segment = 0;
    seg_count = 0;
    nonempty_count = 0;
    overflowed = 1'b0;
  endfunction

  function automatic bit predict_segment(input logic [dss_pkg::BYTE_W-1:0] b,
                                         input logic is_last, output segment_t seg);
    int eff_len;
    int endp;
    int s_start;
    int s_len;
    int k;
    bit hit;
    bit fire;
    eff_len = (delim_len > dss_pkg::MAX_DELIM_DEF) ? dss_pkg::MAX_DELIM_DEF : int'(delim_len);
    history = {history[55:0], b};
    if (position >= dss_pkg::MAX_LEN_DEF) overflowed = 1'b1;
    else position++;
    endp = position;
    if (in_segment < 8) in_segment++;
    // pattern byte 0 is the oldest byte of the window
    hit = (eff_len > 0) && (in_segment >= eff_len);
    for (k = 0; k < eff_len; k++)
      if (history[8*(eff_len-1-k) +: 8] != delim_pattern[8*k +: 8]) hit = 1'b0;
    fire = hit || is_last;
    seg = '0;
    s_start = seg_base;
    if (hit) begin
      s_len = (endp >= s_start + eff_len) ? endp - eff_len - s_start : 0;
      seg_base = endp;
      in_segment = 0;
    end else begin
      s_len = (endp >= s_start) ? endp - s_start : 0;
    end
    if (fire) begin
      if (seg_count < 65535) seg_count++;
      if (s_len > 0 && nonempty_count < 65535) nonempty_count++;
      seg.start    = clamp16(s_start);
      seg.length   = clamp16(s_len);
      seg.fin      = is_last;
      seg.total    = seg_count[dss_pkg::FIELD_W-1:0];
      seg.nonempty = nonempty_count[dss_pkg::FIELD_W-1:0];
      seg.ovf      = overflowed;
    end
    if (is_last) clear_string();
    return fire;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    segment_t want;
    segment_t got;
    if (rst) begin
      delim_pattern = dss_pkg::DELIM_BYTES_RST;
      delim_len = dss_pkg::DELIM_LEN_RST;
      clear_string();
      expected_segments.delete();
    end else begin
      // retire before predicting: a result never belongs to the byte taken at the same edge
      if (out_valid && out_ready) begin
        got = {segment_start, segment_length, final_segment,
               segment_total, nonempty_total, length_overflow};
        if (expected_segments.size() == 0) begin
          errors++;
          $display("%0t: unexpected segment, expected none, got start %0d length %0d",
                   $time, got.start, got.length);
        end else begin
          want = expected_segments.pop_front();
          check_field("segment_start", want.start, got.start);
          check_field("segment_length", want.length, got.length);
          check_field("final_segment", want.fin, got.fin);
          check_field("segment_total", want.total, got.total);
          check_field("nonempty_total", want.nonempty, got.nonempty);
          check_field("length_overflow", want.ovf, got.ovf);
        end
      end
      if (in_valid && in_ready)
        if (predict_segment(text_byte, end_of_string, want)) expected_segments.push_back(want);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dss_pkg::REG_DELIM_BYTES: delim_pattern = cfg_data;
          dss_pkg::REG_DELIM_LEN: delim_len = cfg_data[dss_pkg::DELIM_LEN_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches <= errors;
    pending <= expected_segments.size();
  end

endmodule

// File: tb/delimiter_segment_splitter_tb.sv
// Testbench top for the delimiter segment splitter: clock, reset, stimulus and verdict.
module delimiter_segment_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_BYTES    = 40;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  dss_pkg::cfg_idx_t                  cfg_index = dss_pkg::REG_DELIM_BYTES;
  logic [dss_pkg::DELIM_BYTES_W-1:0]  cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [dss_pkg::BYTE_W-1:0]         text_byte = '0;
  logic                               end_of_string = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [dss_pkg::FIELD_W-1:0]        segment_start;
  logic [dss_pkg::FIELD_W-1:0]        segment_length;
  logic                               final_segment;
  logic [dss_pkg::FIELD_W-1:0]        segment_total;
  logic [dss_pkg::FIELD_W-1:0]        nonempty_total;
  logic                               length_overflow;

  int                                 mismatches;
  int                                 pending;
  bit                                 idling = 1'b1;
  int                                 stall_left = 0;
  int                                 quiet_cycles = 0;

  logic [dss_pkg::DELIM_BYTES_W-1:0]  cur_pattern = dss_pkg::DELIM_BYTES_RST;
  int                                 cur_len = 1;
  logic [dss_pkg::BYTE_W-1:0]         str_q[$];

  delimiter_segment_splitter uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .end_of_string(end_of_string),
    .out_valid(out_valid), .out_ready(out_ready),
    .segment_start(segment_start), .segment_length(segment_length),
    .final_segment(final_segment), .segment_total(segment_total),
    .nonempty_total(nonempty_total), .length_overflow(length_overflow)
  );

  delimiter_segment_splitter_checker segment_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .end_of_string(end_of_string),
    .out_valid(out_valid), .out_ready(out_ready),
    .segment_start(segment_start), .segment_length(segment_length),
    .final_segment(final_segment), .segment_total(segment_total),
    .nonempty_total(nonempty_total), .length_overflow(length_overflow),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // random receiver back-pressure in bursts, only while idling
  always @(posedge clk) begin
    if (!idling) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [dss_pkg::BYTE_W-1:0] b, input logic is_last);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_string <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_string();
    int i;
    for (i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  // drop valid and hold until every segment is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_delimiter(input logic [dss_pkg::DELIM_BYTES_W-1:0] pattern,
                               input logic [dss_pkg::DELIM_LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_index <= dss_pkg::REG_DELIM_BYTES;
    cfg_data <= pattern;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= dss_pkg::REG_DELIM_LEN;
    cfg_data <= dss_pkg::DELIM_BYTES_W'(len);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_pattern = pattern;
    cur_len = (len > dss_pkg::MAX_DELIM_DEF) ? dss_pkg::MAX_DELIM_DEF : int'(len);
  endtask

  // mostly whole delimiters and partial ones around pattern-like bytes, some plain noise
  task automatic build_string(input int target);
    int k;
    int n;
    int r;
    while (str_q.size() < target) begin
      r = $urandom_range(0, 9);
      if (r < 3 && cur_len > 0) begin
        for (k = 0; k < cur_len; k++) str_q.push_back(cur_pattern[8*k +: 8]);
      end else if (r < 5 && cur_len > 1) begin
        n = $urandom_range(1, cur_len - 1);
        for (k = 0; k < n; k++) str_q.push_back(cur_pattern[8*k +: 8]);
      end else if (r < 8 && cur_len > 0) begin
        n = $urandom_range(0, cur_len - 1);
        str_q.push_back(cur_pattern[8*n +: 8]);
      end else begin
        str_q.push_back(dss_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int p;
    int k;
    int phase_bytes;
    logic [dss_pkg::DELIM_BYTES_W-1:0] pat;
    logic [dss_pkg::DELIM_LEN_W-1:0] len;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset delimiter: a single zero byte
    str_q = '{8'h41, 8'h00, 8'h42, 8'h00};
    send_string();
    str_q = '{8'h00};
    send_string();
    str_q = '{8'hFF};
    send_string();
    str_q = '{8'h00, 8'h00, 8'h41};
    send_string();
    settle();

    // leftmost, non-overlapping matches
    set_delimiter(64'h6261, 4'd2);
    str_q = '{8'h61, 8'h61, 8'h62, 8'h61, 8'h62, 8'h62};
    send_string();
    settle();
    set_delimiter(64'h6161, 4'd2);
    str_q = '{8'h61, 8'h61, 8'h61};
    send_string();
    settle();
    set_delimiter(64'h0, 4'd0);
    str_q = '{8'h78, 8'h79};
    send_string();
    settle();
    // a length above the maximum acts as the maximum; the match ends on the final byte
    set_delimiter('1, 4'd15);
    repeat (8) str_q.push_back(8'hFF);
    send_string();
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      for (k = 0; k < 8; k++)
        pat[8*k +: 8] = ($urandom_range(0, 2) == 0) ?
                        dss_pkg::BYTE_W'($urandom_range(0, 255)) :
                        ($urandom_range(0, 1) == 1) ? 8'h61 : 8'h62;
      case (p)
        0: begin
          len = 4'd0;
          pat = {$urandom, $urandom};
        end
        1: begin
          len = 4'd8;
          pat = '1;
        end
        2: len = 4'd15;
        3: begin
          len = 4'd1;
          pat = '0;
        end
        default: len = dss_pkg::DELIM_LEN_W'($urandom_range(1, 15));
      endcase
      if (p >= RANDOM_PHASES - 2) idling <= 1'b0;
      set_delimiter(pat, len);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_string(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24));
        phase_bytes += str_q.size();
        send_string();
      end
      settle();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
